// ===== src/yrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB package
// Shared widths, coefficients, pixel types and the per-pixel color conversion.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int FRAME_PIXEL_BITS = 24;
  localparam int QUEUE_DEPTH      = 4;
  localparam int MEAN_BITS        = 8;
  localparam int PIXELS_PER_BEAT  = 2;
  localparam int SUM_W            = 20;

  localparam logic signed [SUM_W-1:0] COEF_Y        = 20'sd298;
  localparam logic signed [SUM_W-1:0] COEF_RV       = 20'sd409;
  localparam logic signed [SUM_W-1:0] COEF_BU       = 20'sd516;
  localparam logic signed [SUM_W-1:0] COEF_GU       = 20'sd100;
  localparam logic signed [SUM_W-1:0] COEF_GV       = 20'sd208;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS    = 20'sd128;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 20'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 20'sd128;
  localparam logic [7:0]              CHANNEL_MAX   = 8'd255;
  localparam logic [MEAN_BITS-1:0]    MEAN_MAX      = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    rgb_pixel_t first;
    rgb_pixel_t second;
  } rgb_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BACK_IDLE   = 3'b001,
    BACK_DIVIDE = 3'b010,
    BACK_DONE   = 3'b100
  } back_state_t;

  function automatic logic signed [SUM_W-1:0] center_chroma(input logic [7:0] value);
    return $signed({{(SUM_W-8){1'b0}}, value}) - CHROMA_OFFSET;
  endfunction

  // Floor shift by 8 followed by a clamp to the 8-bit range.
  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [7:0] result;
    if (sum[SUM_W-1]) begin
      result = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      result = CHANNEL_MAX;
    end else begin
      result = sum[15:8];
    end
    return result;
  endfunction

  function automatic rgb_pixel_t convert_pixel(input logic [7:0] luma,
                                               input logic signed [SUM_W-1:0] d,
                                               input logic signed [SUM_W-1:0] e);
    logic signed [SUM_W-1:0] c;
    logic signed [SUM_W-1:0] luma_term;
    rgb_pixel_t              px;
    c         = $signed({{(SUM_W-8){1'b0}}, luma}) - LUMA_OFFSET;
    luma_term = COEF_Y * c;
    px.red    = clamp_channel(luma_term + COEF_RV * e + ROUND_BIAS);
    px.green  = clamp_channel(luma_term - COEF_GU * d - COEF_GV * e + ROUND_BIAS);
    px.blue   = clamp_channel(luma_term + COEF_BU * d + ROUND_BIAS);
    return px;
  endfunction

endpackage

// ===== src/yrgb_front.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB front end
// Accepts macropixels, converts both pixels and keeps the frame luma sums.
// ----------------------------------------------------------------------------
module yrgb_front #(
  parameter int FRAME_PIXEL_BITS = yrgb_pkg::FRAME_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     luma_first,
  input  logic [7:0]                     chroma_blue,
  input  logic [7:0]                     luma_second,
  input  logic [7:0]                     chroma_red,
  input  logic                           end_of_frame,
  input  yrgb_pkg::queue_status_t        queue_status,
  output logic                           push,
  output yrgb_pkg::rgb_pair_t            push_pair,
  output logic                           push_eof,
  output logic [FRAME_PIXEL_BITS+7:0]    push_luma,
  output logic [FRAME_PIXEL_BITS:0]      push_pixel
);

  localparam int LUMA_W  = FRAME_PIXEL_BITS + 8;
  localparam int PIXEL_W = FRAME_PIXEL_BITS + 1;

  logic [LUMA_W-1:0]               luma_total;
  logic [PIXEL_W-1:0]              pixel_total;
  logic [LUMA_W:0]                 luma_sum;
  logic [PIXEL_W:0]                pixel_sum;
  logic signed [yrgb_pkg::SUM_W-1:0] d;
  logic signed [yrgb_pkg::SUM_W-1:0] e;

  assign in_stall = queue_status.full;
  assign push     = in_valid && !queue_status.full;

  assign d = yrgb_pkg::center_chroma(chroma_blue);
  assign e = yrgb_pkg::center_chroma(chroma_red);

  assign push_pair.first  = yrgb_pkg::convert_pixel(luma_first, d, e);
  assign push_pair.second = yrgb_pkg::convert_pixel(luma_second, d, e);

  assign luma_sum  = {1'b0, luma_total} + (LUMA_W+1)'(luma_first)
                   + (LUMA_W+1)'(luma_second);
  assign pixel_sum = {1'b0, pixel_total} + (PIXEL_W+1)'(yrgb_pkg::PIXELS_PER_BEAT);

  // Both totals saturate at full scale instead of wrapping.
  assign push_luma  = luma_sum[LUMA_W] ? {LUMA_W{1'b1}} : luma_sum[LUMA_W-1:0];
  assign push_pixel = pixel_sum[PIXEL_W] ? {PIXEL_W{1'b1}} : pixel_sum[PIXEL_W-1:0];
  assign push_eof   = end_of_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_total  <= '0;
      pixel_total <= '0;
    end else if (push) begin
      if (end_of_frame) begin
        luma_total  <= '0;
        pixel_total <= '0;
      end else begin
        luma_total  <= push_luma;
        pixel_total <= push_pixel;
      end
    end
  end

endmodule

// ===== src/yrgb_queue.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB queue
// Short queue of converted beats between the front end and the back end.
// ----------------------------------------------------------------------------
module yrgb_queue #(
  parameter int FRAME_PIXEL_BITS = yrgb_pkg::FRAME_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  yrgb_pkg::rgb_pair_t            push_pair,
  input  logic                           push_eof,
  input  logic [FRAME_PIXEL_BITS+7:0]    push_luma,
  input  logic [FRAME_PIXEL_BITS:0]      push_pixel,
  input  logic                           pop,
  output yrgb_pkg::rgb_pair_t            head_pair,
  output logic                           head_eof,
  output logic [FRAME_PIXEL_BITS+7:0]    head_luma,
  output logic [FRAME_PIXEL_BITS:0]      head_pixel,
  output yrgb_pkg::queue_status_t        status
);

  localparam int LUMA_W  = FRAME_PIXEL_BITS + 8;
  localparam int PIXEL_W = FRAME_PIXEL_BITS + 1;
  localparam int DEPTH   = yrgb_pkg::QUEUE_DEPTH;
  localparam int PTR_W   = $clog2(DEPTH);

  yrgb_pkg::rgb_pair_t pair_mem  [DEPTH];
  logic                eof_mem   [DEPTH];
  logic [LUMA_W-1:0]   luma_mem  [DEPTH];
  logic [PIXEL_W-1:0]  pixel_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign status.full  = (count == (PTR_W+1)'(DEPTH));
  assign status.empty = (count == '0);

  assign head_pair  = pair_mem[rd_ptr];
  assign head_eof   = eof_mem[rd_ptr];
  assign head_luma  = luma_mem[rd_ptr];
  assign head_pixel = pixel_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      pair_mem[wr_ptr]  <= push_pair;
      eof_mem[wr_ptr]   <= push_eof;
      luma_mem[wr_ptr]  <= push_luma;
      pixel_mem[wr_ptr] <= push_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) push |-> !status.full)
    else $error("Beat written into a full queue.");
  assert property (@(posedge clk) disable iff (rst) pop |-> !status.empty)
    else $error("Beat taken from an empty queue.");
`endif

endmodule

// ===== src/yrgb_back.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB back end
// Drains the queue into the output register and forms the frame mean luma.
// ----------------------------------------------------------------------------
module yrgb_back #(
  parameter int FRAME_PIXEL_BITS = yrgb_pkg::FRAME_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  yrgb_pkg::queue_status_t        queue_status,
  input  yrgb_pkg::rgb_pair_t            head_pair,
  input  logic                           head_eof,
  input  logic [FRAME_PIXEL_BITS+7:0]    head_luma,
  input  logic [FRAME_PIXEL_BITS:0]      head_pixel,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     red_first,
  output logic [7:0]                     green_first,
  output logic [7:0]                     blue_first,
  output logic [7:0]                     red_second,
  output logic [7:0]                     green_second,
  output logic [7:0]                     blue_second,
  output logic [7:0]                     mean_luma,
  output logic                           mean_valid
);

  localparam int MB     = yrgb_pkg::MEAN_BITS;
  localparam int DIV_W  = FRAME_PIXEL_BITS + 1 + MB;
  localparam int STEP_W = $clog2(MB + 1);

  yrgb_pkg::back_state_t state;
  yrgb_pkg::back_state_t state_next;

  yrgb_pkg::rgb_pair_t out_pair;
  yrgb_pkg::rgb_pair_t work_pair;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dsh;
  logic [MB-1:0]       quo;
  logic [STEP_W-1:0]   step;
  logic                zero_div;
  logic                sat;

  logic             out_free;
  logic             load_direct;
  logic             start;
  logic             finish;
  logic             fits;
  logic [MB-1:0]    mean_result;

  assign out_free    = !out_valid || !out_stall;
  assign pop         = (state == yrgb_pkg::BACK_IDLE) && !queue_status.empty
                       && (head_eof || out_free);
  assign load_direct = pop && !head_eof;
  assign start       = pop && head_eof;
  assign finish      = (state == yrgb_pkg::BACK_DONE) && out_free;
  assign fits        = (rem >= dsh);
  assign mean_result = zero_div ? '0 : (sat ? yrgb_pkg::MEAN_MAX : quo);

  always_comb begin
    state_next = state;
    case (state)
      yrgb_pkg::BACK_IDLE: begin
        if (start) begin
          state_next = yrgb_pkg::BACK_DIVIDE;
        end
      end
      yrgb_pkg::BACK_DIVIDE: begin
        if (step == '0) begin
          state_next = yrgb_pkg::BACK_DONE;
        end
      end
      yrgb_pkg::BACK_DONE: begin
        if (finish) begin
          state_next = yrgb_pkg::BACK_IDLE;
        end
      end
      default: state_next = yrgb_pkg::BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= yrgb_pkg::BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct || finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Restoring division: the first step only tests for a quotient above the
  // 8-bit range, each later step yields one quotient bit.
  always_ff @(posedge clk) begin
    if (start) begin
      work_pair <= head_pair;
      rem       <= DIV_W'(head_luma);
      dsh       <= {head_pixel, {MB{1'b0}}};
      quo       <= '0;
      step      <= STEP_W'(MB);
      zero_div  <= (head_pixel == '0);
      sat       <= 1'b0;
    end else if (state == yrgb_pkg::BACK_DIVIDE) begin
      if (step == STEP_W'(MB)) begin
        sat <= fits;
      end else begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quo <= {quo[MB-2:0], fits};
      end
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_pair   <= head_pair;
      mean_luma  <= '0;
      mean_valid <= 1'b0;
    end else if (finish) begin
      out_pair   <= work_pair;
      mean_luma  <= mean_result;
      mean_valid <= 1'b1;
    end
  end

  assign red_first    = out_pair.first.red;
  assign green_first  = out_pair.first.green;
  assign blue_first   = out_pair.first.blue;
  assign red_second   = out_pair.second.red;
  assign green_second = out_pair.second.green;
  assign blue_second  = out_pair.second.blue;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    (state == yrgb_pkg::BACK_DIVIDE) && (step < STEP_W'(MB)) && !sat
      |-> ({1'b0, rem} < {dsh, 1'b0}))
    else $error("Division remainder out of range.");
  assert property (@(posedge clk) disable iff (rst)
    finish && zero_div |=> out_valid && mean_valid && (mean_luma == '0))
    else $error("Empty frame did not report a zero mean.");
`endif

endmodule

// ===== src/yuyv_to_rgb_with_mean_luma_unit.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB converter with frame mean luma
// Converts YUYV macropixels to two RGB888 pixels and reports the mean luma.
// ----------------------------------------------------------------------------
// Input beats carry one macropixel on in_valid / in_stall; output beats carry
// two converted pixels plus mean_luma and mean_valid on out_valid / out_stall.
// Every input beat yields exactly one output beat, in order.
// A beat is converted as it enters and waits in a four-entry queue. An
// ordinary beat then passes through the output register, and the block
// sustains one beat per cycle while the output is not stalled and no
// frame mean is being divided. A beat marked end_of_frame runs through a
// restoring divider that makes one quotient bit a cycle; the queue keeps
// accepting meanwhile until its four entries are full, then in_stall rises.
// A stalled output holds its beat unchanged; the queue then fills and the
// stall reaches the input side.
// Reset empties the queue, clears out_valid and both frame totals. The
// totals saturate at full scale; the mean is clamped to 255.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_with_mean_luma_unit #(
  parameter int FRAME_PIXEL_BITS = yrgb_pkg::FRAME_PIXEL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] luma_first,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] luma_second,
  input  logic [7:0] chroma_red,
  input  logic       end_of_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_first,
  output logic [7:0] green_first,
  output logic [7:0] blue_first,
  output logic [7:0] red_second,
  output logic [7:0] green_second,
  output logic [7:0] blue_second,
  output logic [7:0] mean_luma,
  output logic       mean_valid
);

  yrgb_pkg::queue_status_t       queue_status;
  logic                          push;
  yrgb_pkg::rgb_pair_t           push_pair;
  logic                          push_eof;
  logic [FRAME_PIXEL_BITS+7:0]   push_luma;
  logic [FRAME_PIXEL_BITS:0]     push_pixel;
  logic                          pop;
  yrgb_pkg::rgb_pair_t           head_pair;
  logic                          head_eof;
  logic [FRAME_PIXEL_BITS+7:0]   head_luma;
  logic [FRAME_PIXEL_BITS:0]     head_pixel;

  yrgb_front #(.FRAME_PIXEL_BITS(FRAME_PIXEL_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma_first   (luma_first),
    .chroma_blue  (chroma_blue),
    .luma_second  (luma_second),
    .chroma_red   (chroma_red),
    .end_of_frame (end_of_frame),
    .queue_status (queue_status),
    .push         (push),
    .push_pair    (push_pair),
    .push_eof     (push_eof),
    .push_luma    (push_luma),
    .push_pixel   (push_pixel)
  );

  yrgb_queue #(.FRAME_PIXEL_BITS(FRAME_PIXEL_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pair  (push_pair),
    .push_eof   (push_eof),
    .push_luma  (push_luma),
    .push_pixel (push_pixel),
    .pop        (pop),
    .head_pair  (head_pair),
    .head_eof   (head_eof),
    .head_luma  (head_luma),
    .head_pixel (head_pixel),
    .status     (queue_status)
  );

  yrgb_back #(.FRAME_PIXEL_BITS(FRAME_PIXEL_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_status (queue_status),
    .head_pair    (head_pair),
    .head_eof     (head_eof),
    .head_luma    (head_luma),
    .head_pixel   (head_pixel),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_first    (red_first),
    .green_first  (green_first),
    .blue_first   (blue_first),
    .red_second   (red_second),
    .green_second (green_second),
    .blue_second  (blue_second),
    .mean_luma    (mean_luma),
    .mean_valid   (mean_valid)
  );

endmodule

// ===== tb/sv/tb_yuyv_to_rgb_with_mean_luma_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the YUYV to RGB converter with frame mean luma
// Drives macropixel beats, predicts both RGB pixels, mean_luma and mean_valid
// of every beat, and compares each output beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_yuyv_to_rgb_with_mean_luma_unit;

  localparam int     PIXEL_BITS = yrgb_pkg::FRAME_PIXEL_BITS;
  localparam longint LUMA_FULL  = (longint'(1) << (PIXEL_BITS + 8)) - 1;
  localparam longint COUNT_FULL = (longint'(1) << (PIXEL_BITS + 1)) - 1;

  typedef struct packed {
    logic [5:0][7:0] chan;
    logic [7:0]      mean;
    logic            mean_flag;
  } rgb_beat_t;

  class rgb_scoreboard;
    longint    luma_sum;
    longint    pixel_count;
    rgb_beat_t expected_q[$];
    string     chan_name[6];
    int        errors;

    function new();
      luma_sum     = 0;
      pixel_count  = 0;
      errors       = 0;
      chan_name[0] = "red_first";
      chan_name[1] = "green_first";
      chan_name[2] = "blue_first";
      chan_name[3] = "red_second";
      chan_name[4] = "green_second";
      chan_name[5] = "blue_second";
    endfunction

    function logic [7:0] to_channel(int sum);
      int q;
      q = sum >>> 8;
      if (q < 0) begin
        q = 0;
      end else if (q > 255) begin
        q = 255;
      end
      return q[7:0];
    endfunction

    function logic [2:0][7:0] to_rgb(logic [7:0] luma, int d, int e);
      logic [2:0][7:0] px;
      int              c;
      c     = int'(luma) - 16;
      px[0] = to_channel(298 * c + 409 * e + 128);
      px[1] = to_channel(298 * c - 100 * d - 208 * e + 128);
      px[2] = to_channel(298 * c + 516 * d + 128);
      return px;
    endfunction

    function void note_input(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                             logic [7:0] v, logic eof);
      rgb_beat_t exp;
      int        d;
      int        e;
      longint    q;
      d              = int'(u) - 128;
      e              = int'(v) - 128;
      exp.chan[2:0]  = to_rgb(y0, d, e);
      exp.chan[5:3]  = to_rgb(y1, d, e);
      exp.mean       = 8'd0;
      exp.mean_flag  = 1'b0;
      luma_sum       = luma_sum + y0 + y1;
      if (luma_sum > LUMA_FULL) begin
        luma_sum = LUMA_FULL;
      end
      pixel_count = pixel_count + 2;
      if (pixel_count > COUNT_FULL) begin
        pixel_count = COUNT_FULL;
      end
      if (eof) begin
        q = (pixel_count != 0) ? luma_sum / pixel_count : 0;
        if (q > 255) begin
          q = 255;
        end
        exp.mean      = q[7:0];
        exp.mean_flag = 1'b1;
        luma_sum      = 0;
        pixel_count   = 0;
      end
      expected_q.push_back(exp);
    endfunction

    function void check_result(rgb_beat_t got);
      rgb_beat_t exp;
      if (expected_q.size() == 0) begin
        $error("output beat with no input beat pending");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got.chan[i] !== exp.chan[i]) begin
          $error("%s: expected %0d, got %0d", chan_name[i], exp.chan[i], got.chan[i]);
          errors++;
        end
      end
      if (got.mean !== exp.mean) begin
        $error("mean_luma: expected %0d, got %0d", exp.mean, got.mean);
        errors++;
      end
      if (got.mean_flag !== exp.mean_flag) begin
        $error("mean_valid: expected %0d, got %0d", exp.mean_flag, got.mean_flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] luma_first   = 8'd0;
  logic [7:0] chroma_blue  = 8'd0;
  logic [7:0] luma_second  = 8'd0;
  logic [7:0] chroma_red   = 8'd0;
  logic       end_of_frame = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic [7:0] mean_luma;
  logic       mean_valid;

  int            idle_pct  = 0;
  int            stall_pct = 0;
  rgb_beat_t     observed;
  rgb_scoreboard frame_sb  = new();

  yuyv_to_rgb_with_mean_luma_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma_first   (luma_first),
    .chroma_blue  (chroma_blue),
    .luma_second  (luma_second),
    .chroma_red   (chroma_red),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_first    (red_first),
    .green_first  (green_first),
    .blue_first   (blue_first),
    .red_second   (red_second),
    .green_second (green_second),
    .blue_second  (blue_second),
    .mean_luma    (mean_luma),
    .mean_valid   (mean_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      observed.chan      = {blue_second, green_second, red_second,
                            blue_first, green_first, red_first};
      observed.mean      = mean_luma;
      observed.mean_flag = mean_valid;
      frame_sb.check_result(observed);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(input logic [7:0] y0, input logic [7:0] u,
                           input logic [7:0] y1, input logic [7:0] v,
                           input logic eof);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    luma_first   <= y0;
    chroma_blue  <= u;
    luma_second  <= y1;
    chroma_red   <= v;
    end_of_frame <= eof;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    frame_sb.note_input(y0, u, y1, v, eof);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(15))
      0: b = 8'd0;
      1: b = 8'd255;
      2: b = 8'd16;
      3: b = 8'd235;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic send_frames(input int beat_goal);
    int sent;
    int len;
    sent = 0;
    while (sent < beat_goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
      for (int i = 0; i < len; i++) begin
        send_beat(pick_byte(), pick_byte(), pick_byte(), pick_byte(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Corners of the luma and chroma ranges, closed as one frame.
    for (int k = 0; k < 8; k++) begin
      send_beat(k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0,
                k[0] ? 8'd0 : 8'd255, k[2] ? 8'd255 : 8'd0, k == 7);
    end
    // Single-beat frames: studio black and white, full and empty mean.
    send_beat(8'd16, 8'd128, 8'd235, 8'd128, 1'b1);
    send_beat(8'd255, 8'd128, 8'd255, 8'd128, 1'b1);
    send_beat(8'd0, 8'd128, 8'd0, 8'd128, 1'b1);
    // Mean that truncates, then strong opposite chroma.
    send_beat(8'd1, 8'd90, 8'd2, 8'd240, 1'b0);
    send_beat(8'd0, 8'd60, 8'd0, 8'd30, 1'b1);
    send_beat(8'd100, 8'd255, 8'd101, 8'd0, 1'b0);
    send_beat(8'd200, 8'd0, 8'd201, 8'd255, 1'b1);

    send_frames(315);
    idle_pct  = 66;
    send_frames(315);
    idle_pct  = 0;
    stall_pct = 66;
    send_frames(315);
    idle_pct  = 34;
    stall_pct = 34;
    send_frames(315);

    in_valid <= 1'b0;
    while (frame_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (frame_sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
src/yrgb_pkg.sv
src/yrgb_front.sv
src/yrgb_queue.sv
src/yrgb_back.sv
src/yuyv_to_rgb_with_mean_luma_unit.sv
tb/sv/tb_yuyv_to_rgb_with_mean_luma_unit.sv
